[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the line edit buffer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/leib_pkg.sv]
// ----------------------------------------------------------------------------
// leib_pkg
// shared types and codes for the line edit input buffer
// ----------------------------------------------------------------------------
`default_nettype none

package leib_pkg;

   // ring size default
   localparam int DEFAULT_BUFFER_DEPTH = 128;

   // request kinds
   localparam logic REQ_RX   = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // result sequence codes held by the emit stage
   localparam logic [2:0] SEQ_ECHO  = 3'd0;
   localparam logic [2:0] SEQ_ERASE = 3'd1;
   localparam logic [2:0] SEQ_NL    = 3'd2;
   localparam logic [2:0] SEQ_READ  = 3'd3;
   localparam logic [2:0] SEQ_EMPTY = 3'd4;

   // input beat
   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_beat_type;

   // result beat
   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       last;
      logic       line_committed;
      logic       end_of_line;
   } rsp_beat_type;

   // what one item has left to emit
   typedef struct packed {
      logic [2:0] seq;
      logic [7:0] echo_byte;
   } plan_type;

endpackage

`default_nettype wire

[design/line_edit_input_buffer_unit.sv]
// ----------------------------------------------------------------------------
// line_edit_input_buffer_unit
// canonical line edit receive buffer: byte ring with read, commit and edit
// pointers, echo generation and committed byte readout
// ----------------------------------------------------------------------------
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_ready | req_beat_type (req_type, rx_byte)
//   rsp     | out | rsp_valid / rsp_ready | rsp_beat_type (kind, byte, flags)
//
//   pointers and the ring are updated in the cycle a request beat is taken
//   an item yields 0 to 3 result beats, one per cycle while rsp_ready is high,
//   starting the cycle after it is taken; the result sequencer sets the rate
//   a new request is taken once the last beat of the previous item leaves
//   reset clears the three pointers and the sequencer; the ring needs no clear
//   a stalled rsp holds its beat and blocks the request side after one item
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module line_edit_input_buffer_unit #(
   parameter int BUFFER_DEPTH = leib_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire leib_pkg::req_beat_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output leib_pkg::rsp_beat_type      rsp_data
);

   import leib_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int PTR_W = $clog2(2 * BUFFER_DEPTH);
   localparam logic [PTR_W-1:0] DEPTH_P    = PTR_W'(BUFFER_DEPTH);
   localparam logic [PTR_W-1:0] PTR_TOP    = PTR_W'(2 * BUFFER_DEPTH - 1);
   localparam logic [PTR_W:0]   TWO_DEPTH  = (PTR_W + 1)'(2 * BUFFER_DEPTH);
   localparam logic [PTR_W:0]   DEPTH_WIDE = (PTR_W + 1)'(BUFFER_DEPTH);

   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in;
   logic [PTR_W-1:0] commit_ptr_ff, commit_ptr_in;
   logic [PTR_W-1:0] edit_ptr_ff, edit_ptr_in;

   logic       req_fire;
   logic       take_ok;
   logic       is_erase, is_nl, full;
   logic [PTR_W:0] fill, commit_fill;
   logic       load;
   plan_type   plan;
   logic       wr_en, rd_en;
   logic [7:0] wr_data;
   logic [7:0] ram_data;
   logic       nl_fire, cr_beat;

   // pointer helpers, counters wrap at twice the depth
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_TOP) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_TOP : p - PTR_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_idx(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] q;
      q = (p >= DEPTH_P) ? p - DEPTH_P : p;
      return q[IDX_W-1:0];
   endfunction

   function automatic logic [PTR_W:0] ptr_dist(input logic [PTR_W-1:0] hi,
                                               input logic [PTR_W-1:0] lo);
      logic [PTR_W:0] base;
      base = {1'b0, hi} + ((hi < lo) ? TWO_DEPTH : '0);
      return base - {1'b0, lo};
   endfunction

   assign req_ready = take_ok;
   assign req_fire  = req_valid && req_ready;

   // character classes and ring level
   assign is_erase    = (req_data.rx_byte == CHAR_DEL) || (req_data.rx_byte == CHAR_BS);
   assign is_nl       = (req_data.rx_byte == CHAR_CR) || (req_data.rx_byte == CHAR_LF);
   assign fill        = ptr_dist(edit_ptr_ff, read_ptr_ff);
   assign commit_fill = ptr_dist(commit_ptr_ff, read_ptr_ff);
   assign full        = (fill == DEPTH_WIDE);

   // per item decision: pointer moves, ring access, result plan
   always_comb begin
      read_ptr_in    = read_ptr_ff;
      commit_ptr_in  = commit_ptr_ff;
      edit_ptr_in    = edit_ptr_ff;
      load           = 1'b0;
      plan.seq       = SEQ_ECHO;
      plan.echo_byte = req_data.rx_byte;
      wr_en          = 1'b0;
      wr_data        = req_data.rx_byte;
      rd_en          = 1'b0;
      if (req_fire) begin
         if (req_data.req_type == REQ_READ) begin
            load = 1'b1;
            if (read_ptr_ff == commit_ptr_ff) begin
               plan.seq = SEQ_EMPTY;
            end else begin
               plan.seq    = SEQ_READ;
               rd_en       = 1'b1;
               read_ptr_in = ptr_next(read_ptr_ff);
            end
         end else if (is_erase) begin
            if (edit_ptr_ff != commit_ptr_ff) begin
               load        = 1'b1;
               plan.seq    = SEQ_ERASE;
               edit_ptr_in = ptr_prev(edit_ptr_ff);
            end
         end else if (is_nl) begin
            load          = 1'b1;
            plan.seq      = SEQ_NL;
            commit_ptr_in = edit_ptr_ff;
            if (!full) begin
               wr_en         = 1'b1;
               wr_data       = CHAR_LF;
               edit_ptr_in   = ptr_next(edit_ptr_ff);
               commit_ptr_in = ptr_next(edit_ptr_ff);
            end
         end else if ((req_data.rx_byte != CHAR_NUL) && !full) begin
            load        = 1'b1;
            plan.seq    = SEQ_ECHO;
            wr_en       = 1'b1;
            edit_ptr_in = ptr_next(edit_ptr_ff);
         end
      end
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         read_ptr_ff   <= '0;
         commit_ptr_ff <= '0;
         edit_ptr_ff   <= '0;
      end else begin
         read_ptr_ff   <= read_ptr_in;
         commit_ptr_ff <= commit_ptr_in;
         edit_ptr_ff   <= edit_ptr_in;
      end
   end

   // line ring
   leib_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ring_idx(edit_ptr_ff)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ring_idx(read_ptr_ff)),
      .rd_data (ram_data)
   );

   // result beats
   leib_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .plan      (plan),
      .ram_data  (ram_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .take_ok   (take_ok)
   );

   // newline take and the carriage return beat that answers it
   assign nl_fire = req_fire && (req_data.req_type == REQ_RX) && is_nl;
   assign cr_beat = rsp_valid && rsp_data.line_committed && (rsp_data.out_byte == CHAR_CR);

   // ring never holds more than its depth
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill <= DEPTH_WIDE, "ring fill beyond depth")

   // committed end lies between read and edit pointers
   `ASSERT_ALWAYS(a_commit_order, clock, reset, commit_fill <= fill, "commit pointer out of order")

   // a newline beat is followed by its committed echo
   `ASSERT_NEXT(a_nl_echo, clock, reset, nl_fire, cr_beat, "newline echo missing")

endmodule

`default_nettype wire

[design/leib_ram.sv]
// ----------------------------------------------------------------------------
// leib_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module leib_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/leib_emit.sv]
// ----------------------------------------------------------------------------
// leib_emit
// result sequencer: plays out the echo or read beats of one item
// ----------------------------------------------------------------------------
`default_nettype none

module leib_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire leib_pkg::plan_type     plan,
   input  wire logic [7:0]             ram_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output leib_pkg::rsp_beat_type      rsp_data,
   output logic                        take_ok
);

   import leib_pkg::*;

   logic     valid_ff, valid_in;
   logic [1:0] beat_ff, beat_in;
   plan_type plan_ff, plan_in;
   logic [1:0] beat_count;
   logic       is_last;
   logic       rsp_fire;

   // beats per sequence
   always_comb begin
      case (plan_ff.seq)
         SEQ_ERASE: beat_count = 2'd3;
         SEQ_NL:    beat_count = 2'd2;
         default:   beat_count = 2'd1;
      endcase
   end

   assign is_last  = (beat_ff == beat_count - 2'd1);
   assign rsp_fire = valid_ff && rsp_ready;
   assign take_ok  = !valid_ff || (rsp_fire && is_last);

   // beat payload
   always_comb begin
      rsp_data                = '0;
      rsp_data.last           = is_last;
      case (plan_ff.seq)
         SEQ_ECHO: begin
            rsp_data.out_kind = KIND_ECHO;
            rsp_data.out_byte = plan_ff.echo_byte;
         end
         SEQ_ERASE: begin
            rsp_data.out_kind = KIND_ECHO;
            rsp_data.out_byte = (beat_ff == 2'd1) ? CHAR_SPACE : CHAR_BS;
         end
         SEQ_NL: begin
            rsp_data.out_kind       = KIND_ECHO;
            rsp_data.out_byte       = (beat_ff == 2'd0) ? CHAR_CR : CHAR_LF;
            rsp_data.line_committed = 1'b1;
         end
         SEQ_READ: begin
            rsp_data.out_kind    = KIND_DATA;
            rsp_data.out_byte    = ram_data;
            rsp_data.end_of_line = (ram_data == CHAR_LF);
         end
         default: begin
            rsp_data.out_kind = KIND_EMPTY;
            rsp_data.out_byte = CHAR_NUL;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      plan_in  = plan_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = 2'd0;
         plan_in  = plan;
      end else if (rsp_fire) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   // plan payload, no reset
   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

[tb/sv/tb_line_edit_input_buffer_unit.sv]
// ----------------------------------------------------------------------------
// tb_line_edit_input_buffer_unit
// self-checking bench for the line edit input buffer: typed lines, erases,
// newlines and reads go in through a queued driver, a mirror of the ring and
// its three pointers predicts every echo and read beat, and a monitor checks
// each result beat in order under several sender and receiver idling mixes
// ----------------------------------------------------------------------------
module tb_line_edit_input_buffer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import leib_pkg::*;

   localparam int DEPTH       = DEFAULT_BUFFER_DEPTH;
   localparam int PW          = $clog2(2 * DEPTH);
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_CAP   = 50;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   // beats waiting to be sent and results waiting to arrive
   req_beat_type pending_beats[$];
   rsp_beat_type due_beats[$];

   // mirror of the ring and its pointers
   logic [7:0]    mirror_store [DEPTH];
   logic [PW-1:0] rd_pos = '0;
   logic [PW-1:0] cm_pos = '0;
   logic [PW-1:0] ed_pos = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int queued_items   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   line_edit_input_buffer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic void note_echo(input logic [7:0] ch, input logic is_last,
                                     input logic committed);
      rsp_beat_type r;
      r                = '0;
      r.out_kind       = KIND_ECHO;
      r.out_byte       = ch;
      r.last           = is_last;
      r.line_committed = committed;
      due_beats.push_back(r);
   endfunction

   // line discipline mirror: edits the ring and queues the beats it yields
   task automatic apply_line_edit(input req_beat_type b);
      rsp_beat_type  r;
      logic [PW-1:0] fill;
      logic [7:0]    d;
      fill = ed_pos - rd_pos;
      r    = '0;
      if (b.req_type == REQ_READ) begin
         r.last = 1'b1;
         if (rd_pos == cm_pos) begin
            r.out_kind = KIND_EMPTY;
         end else begin
            d             = mirror_store[rd_pos[PW-2:0]];
            rd_pos        = rd_pos + 1'b1;
            r.out_kind    = KIND_DATA;
            r.out_byte    = d;
            r.end_of_line = (d == CHAR_LF);
         end
         due_beats.push_back(r);
      end else if (b.rx_byte == CHAR_DEL || b.rx_byte == CHAR_BS) begin
         // erase only inside the open line
         if (ed_pos != cm_pos) begin
            ed_pos = ed_pos - 1'b1;
            note_echo(CHAR_BS, 1'b0, 1'b0);
            note_echo(CHAR_SPACE, 1'b0, 1'b0);
            note_echo(CHAR_BS, 1'b1, 1'b0);
         end
      end else if (b.rx_byte == CHAR_CR || b.rx_byte == CHAR_LF) begin
         // newline commits even when it cannot be stored
         if (int'(fill) < DEPTH) begin
            mirror_store[ed_pos[PW-2:0]] = CHAR_LF;
            ed_pos = ed_pos + 1'b1;
         end
         cm_pos = ed_pos;
         note_echo(CHAR_CR, 1'b0, 1'b1);
         note_echo(CHAR_LF, 1'b1, 1'b1);
      end else if (b.rx_byte != CHAR_NUL && int'(fill) < DEPTH) begin
         mirror_store[ed_pos[PW-2:0]] = b.rx_byte;
         ed_pos = ed_pos + 1'b1;
         note_echo(b.rx_byte, 1'b1, 1'b0);
      end
   endtask

   // driver: one beat per accept, random gaps from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            apply_line_edit(req_data);
         if (!req_valid || req_ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result beat against the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat kind %0d byte %02h",
                                         rsp_data.out_kind, rsp_data.out_byte));
            end else begin
               want = due_beats.pop_front();
               compare_field("out_kind", rsp_data.out_kind, want.out_kind);
               compare_field("out_byte", rsp_data.out_byte, want.out_byte);
               compare_field("last", rsp_data.last, want.last);
               compare_field("line_committed", rsp_data.line_committed,
                             want.line_committed);
               compare_field("end_of_line", rsp_data.end_of_line, want.end_of_line);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // stimulus helpers
   task automatic queue_beat(input logic kind, input logic [7:0] ch);
      req_beat_type b;
      b.req_type = kind;
      b.rx_byte  = ch;
      pending_beats.push_back(b);
      queued_items++;
   endtask

   function automatic logic [7:0] text_byte(input int noise_pct);
      logic [7:0] ch;
      if ($urandom_range(99) < noise_pct)
         return 8'($urandom_range(255));
      do
         ch = 8'($urandom_range(1, 255));
      while (ch == CHAR_DEL || ch == CHAR_BS || ch == CHAR_CR || ch == CHAR_LF);
      return ch;
   endfunction

   task automatic queue_reads(input int n);
      repeat (n) queue_beat(REQ_READ, 8'($urandom_range(255)));
   endtask

   // one typed line with erases mixed in, usually ended by cr or lf
   task automatic queue_line(input int len, input int erase_pct, input int noise_pct,
                             input int end_pct);
      repeat (len) begin
         if ($urandom_range(99) < erase_pct)
            queue_beat(REQ_RX, $urandom_range(1) ? CHAR_DEL : CHAR_BS);
         else
            queue_beat(REQ_RX, text_byte(noise_pct));
      end
      if ($urandom_range(99) < end_pct)
         queue_beat(REQ_RX, $urandom_range(1) ? CHAR_CR : CHAR_LF);
   endtask

   // lines, read bursts and stray beats
   task automatic queue_mixed(input int n);
      int start;
      int pick;
      start = queued_items;
      while (queued_items - start < n) begin
         pick = $urandom_range(9);
         if (pick < 4)
            queue_reads($urandom_range(1, 10));
         else if (pick < 9)
            queue_line($urandom_range(1, 10), 15, 10, 85);
         else
            queue_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
   endtask

   task automatic wait_sent;
      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
   endtask

   initial begin : stimulus
      int start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, byte extremes, nul, erases, commit, reads
      queue_beat(REQ_READ, 8'hFF);
      queue_beat(REQ_RX, 8'h01);
      queue_beat(REQ_RX, 8'hFF);
      queue_beat(REQ_RX, CHAR_NUL);
      queue_beat(REQ_RX, CHAR_DEL);
      queue_beat(REQ_RX, CHAR_BS);
      queue_beat(REQ_RX, CHAR_BS);
      queue_beat(REQ_RX, 8'h80);
      queue_beat(REQ_RX, 8'h41);
      queue_beat(REQ_RX, CHAR_CR);
      queue_reads(4);
      queue_beat(REQ_RX, 8'h7E);
      queue_beat(REQ_RX, CHAR_LF);
      queue_beat(REQ_RX, CHAR_DEL);
      queue_reads(3);
      wait_sent();

      // fill the ring with lines and no reads, then push past full
      start = queued_items;
      while (queued_items - start < 150)
         queue_line($urandom_range(4, 24), 3, 0, 90);
      repeat (4) queue_beat(REQ_RX, text_byte(0));
      queue_beat(REQ_RX, CHAR_DEL);
      queue_beat(REQ_RX, 8'h55);
      queue_beat(REQ_RX, CHAR_CR);
      wait_sent();

      // sender holds off until every result is in
      while (due_beats.size() != 0) @(posedge clock);

      send_idle_pct  = 60;
      queue_mixed(25);
      wait_sent();

      send_idle_pct  = 0;
      recv_stall_pct = 60;
      queue_mixed(25);
      wait_sent();

      send_idle_pct  = 30;
      recv_stall_pct = 30;
      queue_mixed(25);
      queue_reads(10);
      wait_sent();

      // drain and let the block settle
      while (due_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (due_beats.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", due_beats.size()));
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
